FILE: hw/rtl/sgef_pkg.sv
// Shared widths, register indexes and defaults for the Sobel gradient energy focus core.
package sgef_pkg;

  localparam int PIXEL_W        = 8;
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int SUM_W          = 45;
  localparam int MEAN_W         = 29;
  localparam int FRAC_W         = 8;
  localparam int SOBEL_W        = 11;
  localparam int ENERGY_W       = 21;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 80;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int MIN_DIM        = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int LVL_W          = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

FILE: hw/rtl/sgef_front.sv
// Pixel front end: position counters, line store, 3x3 window, Sobel energy and frame sum.
module sgef_front #(
  parameter int MAX_WIDTH  = sgef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgef_pkg::DEF_MAX_HEIGHT,
  parameter int CNT_W      = $clog2(MAX_WIDTH + 1) + $clog2(MAX_HEIGHT + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [sgef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sgef_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sgef_pkg::PIXEL_W-1:0]  pixel,
  input  logic                          frame_start,
  input  logic [sgef_pkg::LVL_W-1:0]    q_level,
  output logic                          push,
  output logic [sgef_pkg::SUM_W-1:0]    push_sum,
  output logic [CNT_W-1:0]              push_count
);
  import sgef_pkg::*;

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int NEED_W = LVL_W + 2;
  localparam int RST_W  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H  = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  // geometry, clamped at write time
  logic [WW-1:0]    width_eff;
  logic [HW-1:0]    height_eff;
  logic [CNT_W-1:0] win_count;
  logic [31:0]      cfg_wide;

  assign cfg_wide = 32'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(RST_W);
      height_eff <= HW'(RST_H);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (cfg_wide < 32'(MIN_DIM)) width_eff <= WW'(MIN_DIM);
          else if (cfg_wide > 32'(MAX_WIDTH)) width_eff <= WW'(MAX_WIDTH);
          else width_eff <= WW'(cfg_wide);
        end
        REG_FRAME_HEIGHT: begin
          if (cfg_wide < 32'(MIN_DIM)) height_eff <= HW'(MIN_DIM);
          else if (cfg_wide > 32'(MAX_HEIGHT)) height_eff <= HW'(MAX_HEIGHT);
          else height_eff <= HW'(cfg_wide);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    win_count <= CNT_W'(width_eff - WW'(2)) * CNT_W'(height_eff - HW'(2));
  end

  // stage flags
  logic          v1, v2, v3, v4;
  logic          ok1, ok2, ok3, ok4;
  logic          clr1, clr2, clr3, clr4;
  logic          last1, last2, last3, last4;
  logic [2:0]    inflight;
  logic [NEED_W-1:0] need;
  logic          accept;

  assign inflight = 3'(v1 & last1) + 3'(v2 & last2) + 3'(v3 & last3) + 3'(v4 & last4);
  assign need     = NEED_W'(q_level) + NEED_W'(inflight);
  assign s_tready = need < NEED_W'(QUEUE_DEPTH);
  assign accept   = s_tvalid & s_tready;

  // position
  logic [CW-1:0] col, col_cur, col_next;
  logic [RW-1:0] row, row_cur, row_next;
  logic [WW-1:0] col_plus;
  logic [HW-1:0] row_plus;
  logic          row_end, frame_end;

  always_comb begin
    col_cur   = frame_start ? '0 : col;
    row_cur   = frame_start ? '0 : row;
    col_plus  = WW'(col_cur) + WW'(1);
    row_plus  = HW'(row_cur) + HW'(1);
    row_end   = col_plus >= width_eff;
    frame_end = row_end && (row_plus >= height_eff);
    col_next  = row_end ? '0 : CW'(col_plus);
    if (!row_end) row_next = row_cur;
    else if (frame_end) row_next = '0;
    else row_next = RW'(row_plus);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // line store: [2P-1:P] two rows up, [P-1:0] one row up
  logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_W-1:0] rd_word, fwd_word, cur_word, wr_word;
  logic                 fwd;
  logic [CW-1:0]        addr1;
  logic [PIXEL_W-1:0]   px1;

  assign cur_word = fwd ? fwd_word : rd_word;
  assign wr_word  = {cur_word[PIXEL_W-1:0], px1};

  always_ff @(posedge clk) begin
    if (accept) rd_word <= line_mem[col_cur];
    if (v1) line_mem[addr1] <= wr_word;
  end

  always_ff @(posedge clk) begin
    fwd      <= v1 && (addr1 == col_cur);
    fwd_word <= wr_word;
    addr1    <= col_cur;
    px1      <= pixel;
    ok1      <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    clr1     <= frame_start;
    last1    <= frame_end;
  end

  // window: [row top..bottom][col left..right]
  logic [PIXEL_W-1:0] win [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) win[k][j] <= '0;
      end
    end else if (v1) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= cur_word[2*PIXEL_W-1:PIXEL_W];
      win[1][2] <= cur_word[PIXEL_W-1:0];
      win[2][2] <= px1;
    end
  end

  // gradients
  logic [SOBEL_W-2:0]        sx_pos, sx_neg, sy_pos, sy_neg;
  logic signed [SOBEL_W-1:0] sx, sy, sx3, sy3;

  always_comb begin
    sx_pos = (SOBEL_W-1)'(win[0][2]) + {(SOBEL_W-2)'(win[1][2]), 1'b0}
             + (SOBEL_W-1)'(win[2][2]);
    sx_neg = (SOBEL_W-1)'(win[0][0]) + {(SOBEL_W-2)'(win[1][0]), 1'b0}
             + (SOBEL_W-1)'(win[2][0]);
    sy_pos = (SOBEL_W-1)'(win[2][0]) + {(SOBEL_W-2)'(win[2][1]), 1'b0}
             + (SOBEL_W-1)'(win[2][2]);
    sy_neg = (SOBEL_W-1)'(win[0][0]) + {(SOBEL_W-2)'(win[0][1]), 1'b0}
             + (SOBEL_W-1)'(win[0][2]);
    sx = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
    sy = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
  end

  always_ff @(posedge clk) begin
    sx3 <= sx;
    sy3 <= sy;
  end

  logic signed [2*SOBEL_W-1:0] sqx, sqy;
  logic [ENERGY_W-1:0]         energy4;

  assign sqx = sx3 * sx3;
  assign sqy = sy3 * sy3;

  always_ff @(posedge clk) begin
    energy4 <= sqx[ENERGY_W-1:0] + sqy[ENERGY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ok2   <= ok1;
    ok3   <= ok2;
    ok4   <= ok3;
    clr2  <= clr1;
    clr3  <= clr2;
    clr4  <= clr3;
    last2 <= last1;
    last3 <= last2;
    last4 <= last3;
  end

  // frame sum, saturating
  logic [SUM_W-1:0] acc, acc_base, acc_sat;
  logic [SUM_W:0]   acc_sum;

  always_comb begin
    acc_base = clr4 ? '0 : acc;
    acc_sum  = {1'b0, acc_base} + (ok4 ? (SUM_W+1)'(energy4) : '0);
    acc_sat  = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (v4) begin
      acc <= last4 ? '0 : acc_sat;
    end
  end

  assign push       = v4 & last4;
  assign push_sum   = acc_sat;
  assign push_count = win_count;

endmodule

FILE: hw/rtl/sgef_fifo.sv
// Short request queue between the pixel front end and the mean divider.
module sgef_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = sgef_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [W-1:0]                push_data,
  input  logic                        pop,
  output logic [W-1:0]                head,
  output logic                        empty,
  output logic [$clog2(DEPTH+1)-1:0]  level
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;

  assign head  = slots[rd_ptr];
  assign empty = (level == '0);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/sgef_back.sv
// Back end: takes a frame request, forms the Q8 mean by restoring division, holds the result.
module sgef_back #(
  parameter int CNT_W = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [sgef_pkg::SUM_W-1:0]  q_sum,
  input  logic [CNT_W-1:0]            q_count,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sgef_pkg::SUM_W-1:0]  sum_out,
  output logic [sgef_pkg::MEAN_W-1:0] mean_out
);
  import sgef_pkg::*;

  localparam int DIV_W  = SUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN, ST_DONE} state_t;

  state_t            state;
  logic [DIV_W-1:0]  dq;
  logic [CNT_W-1:0]  rem, divisor, rem_next;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [STEP_W-1:0] step;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign m_tvalid = (state == ST_DONE);

  always_comb begin
    trial    = {rem, dq[DIV_W-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            dq      <= {q_sum, FRAC_W'(0)};
            divisor <= q_count;
            sum_out <= q_sum;
            rem     <= '0;
            step    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          dq   <= {dq[DIV_W-2:0], ge};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_W - 1)) state <= ST_FIN;
        end
        ST_FIN: begin
          // clamp quotient to the mean field
          mean_out <= (|dq[DIV_W-1:MEAN_W]) ? '1 : dq[MEAN_W-1:0];
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sobel_gradient_energy_focus_core.sv
// Top level of the Sobel gradient energy (Tenengrad) focus core.
//
//   channel | handshake                    | payload
//   --------+------------------------------+-------------------------------------
//   s_      | s_tvalid / s_tready          | s_tdata: pixel; s_tuser: frame_start
//   m_      | m_tvalid / m_tready          | m_tdata: gradient_sum, mean_q8
//   cfg_    | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One pixel per cycle enters the front end while s_tready is high; the mean divider
// forms each frame result in 53 one-bit steps, one frame at a time.
// s_tready drops only while queued plus in-flight frame results fill the 4-entry queue.
// Reset clears counters, window, sum and queue; the line store has no clearing pass.
// cfg_ready is always high; write registers only while the core is idle.
module sobel_gradient_energy_focus_core #(
  parameter int MAX_WIDTH  = sgef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgef_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [sgef_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] pixel
  input  logic [0:0]                         s_tuser,   // [0] frame_start
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [sgef_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [44:0] gradient_sum, [73:45] mean_q8
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sgef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgef_pkg::CFG_W-1:0]         cfg_data
);
  import sgef_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH + 1) + $clog2(MAX_HEIGHT + 1);
  localparam int Q_W   = SUM_W + CNT_W;

  logic               push, q_pop, q_empty;
  logic [SUM_W-1:0]   push_sum, sum_out;
  logic [CNT_W-1:0]   push_count;
  logic [Q_W-1:0]     q_head;
  logic [LVL_W-1:0]   q_level;
  logic [MEAN_W-1:0]  mean_out;

  assign cfg_ready = 1'b1;

  sgef_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .pixel      (s_tdata[PIXEL_W-1:0]),
    .frame_start(s_tuser[0]),
    .q_level    (q_level),
    .push       (push),
    .push_sum   (push_sum),
    .push_count (push_count)
  );

  sgef_fifo #(
    .W    (Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_count, push_sum}),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .level    (q_level)
  );

  sgef_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_sum   (q_head[SUM_W-1:0]),
    .q_count (q_head[Q_W-1:SUM_W]),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sum_out (sum_out),
    .mean_out(mean_out)
  );

  assign m_tdata = {(OUT_TDATA_W - SUM_W - MEAN_W)'(0), mean_out, sum_out};

endmodule

FILE: hw/rtl/sgef_checker.sv
// Port-level checks for the focus core, bound to the top level.
module sgef_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [sgef_pkg::IN_TDATA_W-1:0]    s_tdata,
  input logic [0:0]                         s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [sgef_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [sgef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [sgef_pkg::CFG_W-1:0]         cfg_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_zero_mean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[44:0] == 45'd0) |-> (m_tdata[73:45] == 29'd0))
    else $error("nonzero mean for zero gradient sum");

  // window count is at least one, so the mean never exceeds sum * 256
  a_mean_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({24'd0, m_tdata[73:45]} <= {m_tdata[44:0], 8'd0})
                 && (m_tdata[79:74] == 6'd0))
    else $error("mean above scaled sum or padding set");

endmodule

bind sobel_gradient_energy_focus_core sgef_checker u_sgef_checker (.*);
